// ----- design/avtc_pkg.sv -----
// Shared types and constants of the adaptive video tier controller.
// Used by avtc_cap, avtc_decide and adaptive_video_tier_controller.
`timescale 1ns / 1ps

package avtc_pkg;

    // Quality tiers and the request code for automatic selection.
    localparam logic [2:0] TierLow      = 3'd0;
    localparam logic [2:0] TierMedium   = 3'd1;
    localparam logic [2:0] TierMedHigh  = 3'd2;
    localparam logic [2:0] TierHigh     = 3'd3;
    localparam logic [2:0] TierVeryHigh = 3'd4;
    localparam logic [2:0] TierAuto     = 3'd5;
    localparam logic [2:0] TierAutoCeil = TierMedHigh;

    // Reasons reported with a result word.
    localparam logic [2:0] ReasonNone    = 3'd0;
    localparam logic [2:0] ReasonClient  = 3'd1;
    localparam logic [2:0] ReasonCeiling = 3'd2;
    localparam logic [2:0] ReasonDown    = 3'd3;
    localparam logic [2:0] ReasonUp      = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] RegSessionStart = 3'd0;
    localparam logic [2:0] RegVideoWanted  = 3'd1;
    localparam logic [2:0] RegRateMedium   = 3'd2;
    localparam logic [2:0] RegRateMedHigh  = 3'd3;
    localparam logic [2:0] RegRateHigh     = 3'd4;
    localparam logic [2:0] RegRateVeryHigh = 3'd5;

    // Timing in milliseconds.
    localparam logic [32:0] StartupGraceMs    = 33'd15000;
    localparam logic [32:0] MinReconfMs       = 33'd5000;
    localparam logic [32:0] PostReconfGraceMs = 33'd12000;
    localparam logic [32:0] CooldownMs        = 33'd180000;

    // Streak thresholds and health limits.
    localparam logic [2:0]  BadNeededLow     = 3'd3;
    localparam logic [2:0]  BadNeededHigh    = 3'd6;
    localparam logic [2:0]  BadMax           = 3'd7;
    localparam logic [5:0]  GoodNeededLow    = 6'd10;
    localparam logic [5:0]  GoodNeededHigh   = 6'd45;
    localparam logic [5:0]  GoodMax          = 6'd63;
    localparam logic [9:0]  LossHard         = 10'd100;
    localparam logic [15:0] FramesUpLow      = 16'd8;
    localparam logic [15:0] FramesUpHigh     = 16'd20;
    localparam logic [15:0] FramesMeaningful = 16'd2;

    // Reset values of the configuration registers.
    localparam logic [19:0] RateMediumReset   = 20'd2500;
    localparam logic [19:0] RateMedHighReset  = 20'd6000;
    localparam logic [19:0] RateHighReset     = 20'd12000;
    localparam logic [19:0] RateVeryHighReset = 20'd25000;

    typedef struct packed {
        logic [31:0] session_start_ms;
        logic        video_wanted;
        logic [19:0] rate_medium_kbps;
        logic [19:0] rate_mediumhigh_kbps;
        logic [19:0] rate_high_kbps;
        logic [19:0] rate_veryhigh_kbps;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  current_tier;
        logic [2:0]  bad_streak;
        logic [5:0]  good_streak;
        logic [31:0] last_reconfig_time;
        logic        reconfig_seen;
        logic [31:0] cooldown_end_time;
        logic        cooldown_armed;
    } t_state;

    // Result word, packed so that applied_tier_out sits in the lowest bits.
    typedef struct packed {
        logic       framecount_wanted;
        logic [2:0] change_reason;
        logic       reconfigured;
        logic [2:0] applied_tier_out;
    } t_result;

endpackage

// ----- design/avtc_cap.sv -----
// Bitrate capping of a quality tier against the client limit.
// Depends on avtc_pkg for the tier codes and the configuration struct.
`timescale 1ns / 1ps

module avtc_cap (
    input  avtc_pkg::t_cfg i_cfg,
    input  logic [2:0]     i_tier,
    input  logic [19:0]    i_rate_cap_kbps,
    output logic [2:0]     o_tier
);

    logic [4:0] w_fits;
    logic [2:0] w_clamped;

    always_comb begin
        // Low carries no rate and always fits.
        w_fits[0] = 1'b1;
        w_fits[1] = i_cfg.rate_medium_kbps     <= i_rate_cap_kbps;
        w_fits[2] = i_cfg.rate_mediumhigh_kbps <= i_rate_cap_kbps;
        w_fits[3] = i_cfg.rate_high_kbps       <= i_rate_cap_kbps;
        w_fits[4] = i_cfg.rate_veryhigh_kbps   <= i_rate_cap_kbps;

        w_clamped = (i_tier > avtc_pkg::TierVeryHigh) ? avtc_pkg::TierVeryHigh : i_tier;

        if (i_rate_cap_kbps == 20'd0) begin
            o_tier = w_clamped;
        end else begin
            // Highest tier at or below the request whose rate fits the cap.
            o_tier = avtc_pkg::TierLow;
            for (int k = 1; k <= 4; k++) begin
                if (3'(k) <= w_clamped && w_fits[k]) begin
                    o_tier = 3'(k);
                end
            end
        end
    end

endmodule

// ----- design/avtc_decide.sv -----
// Per-heartbeat tier decision: client requests, auto ceiling, step down and step up.
// Depends on avtc_pkg; the capped tier comes back from avtc_cap.
`timescale 1ns / 1ps

module avtc_decide (
    input  avtc_pkg::t_cfg   i_cfg,
    input  avtc_pkg::t_state i_state,
    input  logic [31:0]      i_now_ms,
    input  logic [2:0]       i_req_tier,
    input  logic [9:0]       i_loss_pm,
    input  logic [15:0]      i_frames_decoded,
    output logic [2:0]       o_target_tier,
    input  logic [2:0]       i_capped_tier,
    output avtc_pkg::t_state o_state,
    output logic             o_reconfigured,
    output logic [2:0]       o_change_reason
);

    logic        w_is_auto;
    logic        w_lossy;
    logic [2:0]  w_auto_target;
    logic [32:0] w_now;
    logic        w_min_ok;
    logic        w_in_startup;
    logic        w_in_post_grace;
    logic [32:0] w_cool_sum;
    logic [2:0]  w_bad_inc;
    logic [5:0]  w_good_inc;
    logic        w_promo;
    logic [5:0]  w_good_need;
    logic [15:0] w_frames_min;
    logic        w_apply;
    logic [2:0]  w_reason;

    always_comb begin
        w_is_auto = i_req_tier == avtc_pkg::TierAuto;
        w_lossy   = i_loss_pm >= avtc_pkg::LossHard;
        if (i_state.current_tier > avtc_pkg::TierAutoCeil) begin
            w_auto_target = avtc_pkg::TierAutoCeil;
        end else if (w_lossy) begin
            w_auto_target = i_state.current_tier - 3'd1;
        end else begin
            w_auto_target = i_state.current_tier + 3'd1;
        end
        o_target_tier = w_is_auto ? w_auto_target : i_req_tier;
    end

    always_comb begin
        w_now           = {1'b0, i_now_ms};
        w_min_ok        = !i_state.reconfig_seen ||
                          w_now >= {1'b0, i_state.last_reconfig_time} + avtc_pkg::MinReconfMs;
        w_in_startup    = w_now < {1'b0, i_cfg.session_start_ms} + avtc_pkg::StartupGraceMs;
        w_in_post_grace = i_state.reconfig_seen &&
                          w_now < {1'b0, i_state.last_reconfig_time} +
                          avtc_pkg::PostReconfGraceMs;
        w_cool_sum      = w_now + avtc_pkg::CooldownMs;
        w_bad_inc       = (i_state.bad_streak < avtc_pkg::BadMax) ?
                          i_state.bad_streak + 3'd1 : i_state.bad_streak;
        w_good_inc      = (i_state.good_streak < avtc_pkg::GoodMax) ?
                          i_state.good_streak + 6'd1 : i_state.good_streak;
        w_promo         = i_state.current_tier + 3'd1 >= avtc_pkg::TierMedHigh;
        w_good_need     = w_promo ? avtc_pkg::GoodNeededHigh : avtc_pkg::GoodNeededLow;
        w_frames_min    = w_promo ? avtc_pkg::FramesUpHigh : avtc_pkg::FramesUpLow;

        o_state  = i_state;
        w_apply  = 1'b0;
        w_reason = avtc_pkg::ReasonNone;

        if (i_cfg.video_wanted) begin
            if (!w_is_auto) begin
                if (i_capped_tier != i_state.current_tier) begin
                    w_apply  = 1'b1;
                    w_reason = avtc_pkg::ReasonClient;
                end
                o_state.bad_streak  = 3'd0;
                o_state.good_streak = 6'd0;
            end else if (!w_in_startup && !w_in_post_grace) begin
                if (i_state.current_tier > avtc_pkg::TierAutoCeil) begin
                    w_apply  = 1'b1;
                    w_reason = avtc_pkg::ReasonCeiling;
                end else if (w_lossy) begin
                    o_state.good_streak = 6'd0;
                    if (w_bad_inc >= ((i_state.current_tier >= avtc_pkg::TierMedHigh) ?
                                      avtc_pkg::BadNeededHigh : avtc_pkg::BadNeededLow)) begin
                        o_state.bad_streak = 3'd0;
                        if (i_state.current_tier > avtc_pkg::TierLow) begin
                            w_apply  = 1'b1;
                            w_reason = avtc_pkg::ReasonDown;
                        end
                        // Leaving a 60 fps tier holds off promotion for a while.
                        if (i_state.current_tier >= avtc_pkg::TierMedHigh) begin
                            o_state.cooldown_end_time = w_cool_sum[32] ?
                                                        32'hFFFF_FFFF : w_cool_sum[31:0];
                            o_state.cooldown_armed    = 1'b1;
                        end
                    end else begin
                        o_state.bad_streak = w_bad_inc;
                    end
                end else begin
                    o_state.bad_streak = 3'd0;
                    if (i_state.current_tier >= avtc_pkg::TierAutoCeil) begin
                        o_state.good_streak = 6'd0;
                    end else if (w_promo && i_frames_decoded == 16'd0) begin
                        o_state.good_streak = 6'd0;
                    end else if (i_frames_decoded >= avtc_pkg::FramesMeaningful &&
                                 i_frames_decoded < w_frames_min) begin
                        o_state.good_streak = 6'd0;
                    end else if (w_promo && i_state.cooldown_armed &&
                                 i_now_ms < i_state.cooldown_end_time) begin
                        o_state.good_streak = 6'd0;
                    end else if (w_good_inc >= w_good_need) begin
                        o_state.good_streak = 6'd0;
                        w_apply  = 1'b1;
                        w_reason = avtc_pkg::ReasonUp;
                    end else begin
                        o_state.good_streak = w_good_inc;
                    end
                end
            end
        end

        o_reconfigured  = 1'b0;
        o_change_reason = avtc_pkg::ReasonNone;
        if (w_apply && w_min_ok) begin
            o_state.current_tier       = i_capped_tier;
            o_state.last_reconfig_time = i_now_ms;
            o_state.reconfig_seen      = 1'b1;
            o_state.bad_streak         = 3'd0;
            o_state.good_streak        = 6'd0;
            o_reconfigured             = 1'b1;
            o_change_reason            = w_reason;
        end
    end

endmodule

// ----- design/adaptive_video_tier_controller.sv -----
// Top level of the adaptive video tier controller: configuration registers,
// controller state and the result register. Depends on avtc_pkg, avtc_cap, avtc_decide.
`timescale 1ns / 1ps

// One heartbeat word is taken per clock, and its result word appears in the
// output register on the next cycle. The decision for a heartbeat is formed
// combinationally from the incoming word and the held state, so consecutive heartbeats
// see each other's state updates with no gap. The input is stalled only while a
// result word waits in the output register and the downstream side is not ready.
// Configuration writes are always accepted and should be made while idle.
module adaptive_video_tier_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Heartbeat input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: now_ms[31:0], req_tier[34:32], rate_cap_kbps[54:35],
    // loss_pm[64:55], frames_decoded[80:65], framecount_request[81], zero pad.
    input  logic [87:0] s_axis_tdata,
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: applied_tier_out[2:0], reconfigured[3], change_reason[6:4],
    // framecount_wanted[7].
    output logic [7:0]  m_axis_tdata
);

    avtc_pkg::t_cfg    r_cfg;
    avtc_pkg::t_state  r_state;
    avtc_pkg::t_state  n_state;
    avtc_pkg::t_result r_result;
    avtc_pkg::t_result n_result;
    logic              r_out_valid;

    logic [2:0] w_target_tier;
    logic [2:0] w_capped_tier;
    logic       w_reconfigured;
    logic [2:0] w_change_reason;
    logic       w_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

    avtc_cap u_cap (
        .i_cfg           (r_cfg),
        .i_tier          (w_target_tier),
        .i_rate_cap_kbps (s_axis_tdata[54:35]),
        .o_tier          (w_capped_tier)
    );

    avtc_decide u_decide (
        .i_cfg            (r_cfg),
        .i_state          (r_state),
        .i_now_ms         (s_axis_tdata[31:0]),
        .i_req_tier       (s_axis_tdata[34:32]),
        .i_loss_pm        (s_axis_tdata[64:55]),
        .i_frames_decoded (s_axis_tdata[80:65]),
        .o_target_tier    (w_target_tier),
        .i_capped_tier    (w_capped_tier),
        .o_state          (n_state),
        .o_reconfigured   (w_reconfigured),
        .o_change_reason  (w_change_reason)
    );

    always_comb begin
        n_result.applied_tier_out  = n_state.current_tier;
        n_result.reconfigured      = w_reconfigured;
        n_result.change_reason     = w_change_reason;
        n_result.framecount_wanted = s_axis_tdata[81];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.session_start_ms     <= 32'd0;
            r_cfg.video_wanted         <= 1'b1;
            r_cfg.rate_medium_kbps     <= avtc_pkg::RateMediumReset;
            r_cfg.rate_mediumhigh_kbps <= avtc_pkg::RateMedHighReset;
            r_cfg.rate_high_kbps       <= avtc_pkg::RateHighReset;
            r_cfg.rate_veryhigh_kbps   <= avtc_pkg::RateVeryHighReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                avtc_pkg::RegSessionStart: r_cfg.session_start_ms     <= i_cfg_data;
                avtc_pkg::RegVideoWanted:  r_cfg.video_wanted         <= i_cfg_data[0];
                avtc_pkg::RegRateMedium:   r_cfg.rate_medium_kbps     <= i_cfg_data[19:0];
                avtc_pkg::RegRateMedHigh:  r_cfg.rate_mediumhigh_kbps <= i_cfg_data[19:0];
                avtc_pkg::RegRateHigh:     r_cfg.rate_high_kbps       <= i_cfg_data[19:0];
                avtc_pkg::RegRateVeryHigh: r_cfg.rate_veryhigh_kbps   <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.current_tier       <= avtc_pkg::TierMedium;
            r_state.bad_streak         <= 3'd0;
            r_state.good_streak        <= 6'd0;
            r_state.last_reconfig_time <= 32'd0;
            r_state.reconfig_seen      <= 1'b0;
            r_state.cooldown_end_time  <= 32'd0;
            r_state.cooldown_armed     <= 1'b0;
            r_out_valid                <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

endmodule
